FILE: rtl/core/pldw_pkg.sv
// ----------------------------------------------------------------------------
// pldw_pkg - shared types and constants of the product-to-LCD decimal writer
// Widths, digit constants, microcode word layout and datapath status.
// ----------------------------------------------------------------------------
package pldw_pkg;

  // Number of decimal digits shown; the product saturates to all nines.
  localparam int MAX_DIGITS = 6;

  localparam int FACTOR_W = 10;
  localparam int MASK_W   = 4;
  localparam int CHAR_W   = 8;
  localparam int NIB_W    = 4;
  localparam int DIGIT_W  = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_MASK = 1'd1;
  localparam logic [MASK_W-1:0] ENABLE_MASK_RST = 4'd8;
  localparam logic [MASK_W-1:0] SELECT_MASK_RST = 4'd4;

  function automatic longint unsigned pow10_c(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam int MUL_W   = 2 * FACTOR_W;
  localparam int LIMIT_W = $clog2(pow10_c(MAX_DIGITS));
  localparam int PROD_W  = (LIMIT_W > MUL_W) ? LIMIT_W : MUL_W;
  localparam logic [PROD_W-1:0] PROD_LIMIT = PROD_W'(pow10_c(MAX_DIGITS) - 1);
  localparam int DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [DIG_IDX_W-1:0] TOP_DIGIT = DIG_IDX_W'(MAX_DIGITS - 1);

  // Weight of a digit position, as a constant table.
  function automatic logic [PROD_W-1:0] pow10_at(input logic [DIG_IDX_W-1:0] k);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < MAX_DIGITS - 1; i++) begin
      if (i < int'(k)) begin
        p = p * 10;
      end
    end
    return PROD_W'(p);
  endfunction

  // Microcode program counter.
  localparam int PC_W = 4;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_MUL  = 3'd1,
    OP_SAT  = 3'd2,
    OP_WORK = 3'd3,
    OP_EMIT = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    PH_SETUP = 2'd0,
    PH_PULSE = 2'd1,
    PH_HOLD  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    COND_NONE = 2'd0,
    COND_SKIP = 2'd1,
    COND_MORE = 2'd2
  } cond_t;

  typedef struct packed {
    op_t             op;
    logic            ext;      // one restoring step of digit extraction
    logic [1:0]      bitsel;   // weight shift of that step
    logic            take;     // commit extracted digit to the char register
    logic            skipck;   // drop a leading zero
    logic            nib_hi;
    phase_t          phase;
    cond_t           cond;
    logic [PC_W-1:0] tgt_t;
    logic [PC_W-1:0] tgt_f;
  } ucode_t;

  typedef struct packed {
    logic skip;   // current digit is a leading zero
    logic last;   // char register holds the final digit
  } dp_stat_t;

endpackage

FILE: rtl/core/pldw_useq.sv
// ----------------------------------------------------------------------------
// pldw_useq - microcode sequencer
// Step counter, control store and conditional branch logic.
// ----------------------------------------------------------------------------
module pldw_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_ready,
  input  pldw_pkg::dp_stat_t stat,
  output pldw_pkg::ucode_t   ctl,
  output logic               go
);

  logic [pldw_pkg::PC_W-1:0] pc_r;
  logic [pldw_pkg::PC_W-1:0] pc_nxt;
  logic                      taken;

  function automatic pldw_pkg::ucode_t rom_word(input logic [pldw_pkg::PC_W-1:0] a);
    pldw_pkg::ucode_t w;
    w.op     = pldw_pkg::OP_WORK;
    w.ext    = 1'b0;
    w.bitsel = 2'd0;
    w.take   = 1'b0;
    w.skipck = 1'b0;
    w.nib_hi = 1'b0;
    w.phase  = pldw_pkg::PH_SETUP;
    w.cond   = pldw_pkg::COND_NONE;
    w.tgt_t  = a + 1'b1;
    w.tgt_f  = a + 1'b1;
    case (a)
      4'd0: begin
        w.op = pldw_pkg::OP_LOAD;
      end
      4'd1: begin
        w.op = pldw_pkg::OP_MUL;
      end
      4'd2: begin
        w.op = pldw_pkg::OP_SAT;
      end
      4'd3, 4'd4, 4'd5, 4'd6: begin
        w.ext    = 1'b1;
        w.bitsel = 2'(4'd6 - a);
      end
      4'd7: begin
        w.take   = 1'b1;
        w.skipck = 1'b1;
        w.cond   = pldw_pkg::COND_SKIP;
        w.tgt_t  = 4'd3;
        w.tgt_f  = 4'd8;
      end
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13: begin
        w.op = pldw_pkg::OP_EMIT;
        // overlap next digit's extraction with the first four writes
        w.ext    = (a < 4'd12);
        w.bitsel = 2'(4'd11 - a);
        w.nib_hi = (a < 4'd11);
        case (a)
          4'd8, 4'd11: w.phase = pldw_pkg::PH_SETUP;
          4'd9, 4'd12: w.phase = pldw_pkg::PH_PULSE;
          default:     w.phase = pldw_pkg::PH_HOLD;
        endcase
        if (a == 4'd13) begin
          w.take  = 1'b1;
          w.cond  = pldw_pkg::COND_MORE;
          w.tgt_t = 4'd8;
          w.tgt_f = 4'd0;
        end
      end
      default: begin
        w.tgt_t = 4'd0;
        w.tgt_f = 4'd0;
      end
    endcase
    return w;
  endfunction

  assign ctl = rom_word(pc_r);

  // Hold the step while waiting on either channel.
  assign go = !((ctl.op == pldw_pkg::OP_LOAD && !in_valid) ||
                (ctl.op == pldw_pkg::OP_EMIT && !out_ready));

  always_comb begin
    case (ctl.cond)
      pldw_pkg::COND_SKIP: taken = stat.skip;
      pldw_pkg::COND_MORE: taken = !stat.last;
      default:             taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (go) begin
      pc_nxt = taken ? ctl.tgt_t : ctl.tgt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/core/pldw_dpath.sv
// ----------------------------------------------------------------------------
// pldw_dpath - datapath
// Factor registers, multiplier, restoring digit extraction, port value build.
// ----------------------------------------------------------------------------
module pldw_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pldw_pkg::ucode_t                    ctl,
  input  logic                                go,
  input  logic [pldw_pkg::FACTOR_W-1:0]       factor_a,
  input  logic [pldw_pkg::FACTOR_W-1:0]       factor_b,
  input  logic [pldw_pkg::MASK_W-1:0]         enable_mask,
  input  logic [pldw_pkg::MASK_W-1:0]         select_mask,
  output pldw_pkg::dp_stat_t                  stat,
  output logic [pldw_pkg::CHAR_W-1:0]         port_value,
  output logic                                last_write
);

  localparam int PW = pldw_pkg::PROD_W;

  logic [pldw_pkg::FACTOR_W-1:0]  fa_r, fa_nxt, fb_r, fb_nxt;
  logic [PW-1:0]                  rem_r, rem_nxt;
  logic [pldw_pkg::DIGIT_W-1:0]   dig_r, dig_nxt, chr_r, chr_nxt;
  logic [pldw_pkg::DIG_IDX_W-1:0] k_r, k_nxt;
  logic                           started_r, started_nxt;
  logic                           lastd_r, lastd_nxt;

  logic [pldw_pkg::MUL_W-1:0]     mul_w;
  logic [PW:0]                    sub_w;
  logic [PW:0]                    diff_w;
  logic                           commit;
  logic [pldw_pkg::CHAR_W-1:0]    ascii_w;
  logic [pldw_pkg::NIB_W-1:0]     nib_w;
  logic [pldw_pkg::CHAR_W-1:0]    nib_byte, e_byte, rs_byte;

  assign mul_w  = pldw_pkg::MUL_W'(fa_r) * pldw_pkg::MUL_W'(fb_r);
  assign sub_w  = {1'b0, pldw_pkg::pow10_at(k_r)} << ctl.bitsel;
  assign diff_w = {1'b0, rem_r} - sub_w;

  assign stat.skip = (dig_r == '0) && (k_r != '0) && !started_r;
  assign stat.last = lastd_r;
  assign commit    = ctl.take && !stat.skip && !lastd_r;

  always_comb begin
    fa_nxt      = fa_r;
    fb_nxt      = fb_r;
    rem_nxt     = rem_r;
    dig_nxt     = dig_r;
    chr_nxt     = chr_r;
    k_nxt       = k_r;
    started_nxt = started_r;
    lastd_nxt   = lastd_r;
    if (go) begin
      case (ctl.op)
        pldw_pkg::OP_LOAD: begin
          fa_nxt = factor_a;
          fb_nxt = factor_b;
        end
        pldw_pkg::OP_MUL: begin
          rem_nxt     = PW'(mul_w);
          k_nxt       = pldw_pkg::TOP_DIGIT;
          started_nxt = 1'b0;
          lastd_nxt   = 1'b0;
        end
        pldw_pkg::OP_SAT: begin
          if (rem_r > pldw_pkg::PROD_LIMIT) begin
            rem_nxt = pldw_pkg::PROD_LIMIT;
          end
        end
        default: begin
        end
      endcase
      // restoring step: subtract the shifted weight if it fits
      if (ctl.ext && !lastd_r) begin
        dig_nxt = {dig_r[pldw_pkg::DIGIT_W-2:0], ~diff_w[PW]};
        if (!diff_w[PW]) begin
          rem_nxt = diff_w[PW-1:0];
        end
      end
      if (ctl.skipck && stat.skip) begin
        k_nxt = k_r - 1'b1;
      end
      if (commit) begin
        chr_nxt     = dig_r;
        started_nxt = 1'b1;
        lastd_nxt   = (k_r == '0);
        if (k_r != '0) begin
          k_nxt = k_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fa_r  <= fa_nxt;
    fb_r  <= fb_nxt;
    rem_r <= rem_nxt;
    dig_r <= dig_nxt;
    chr_r <= chr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      started_r <= 1'b0;
      lastd_r   <= 1'b0;
    end else begin
      k_r       <= k_nxt;
      started_r <= started_nxt;
      lastd_r   <= lastd_nxt;
    end
  end

  // HD44780 4-bit write: nibble in bits 7..4, strobe and select in the low bits.
  assign ascii_w  = pldw_pkg::ASCII_ZERO + pldw_pkg::CHAR_W'(chr_r);
  assign nib_w    = ctl.nib_hi ? ascii_w[7:4] : ascii_w[3:0];
  assign nib_byte = {nib_w, 4'b0000};
  assign e_byte   = pldw_pkg::CHAR_W'(enable_mask);
  assign rs_byte  = pldw_pkg::CHAR_W'(select_mask);

  always_comb begin
    case (ctl.phase)
      pldw_pkg::PH_PULSE: port_value = nib_byte | e_byte | rs_byte;
      pldw_pkg::PH_HOLD:  port_value = (nib_byte & ~e_byte) | rs_byte;
      default:            port_value = nib_byte | rs_byte;
    endcase
  end

  assign last_write = ctl.take && (ctl.op == pldw_pkg::OP_EMIT) && lastd_r;

endmodule

FILE: rtl/core/product_to_lcd_decimal_writer_core.sv
// ----------------------------------------------------------------------------
// product_to_lcd_decimal_writer_core - product to HD44780 decimal writer
// Multiplies two factors and streams the decimal product as LCD port writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries two 10-bit factors per item.
//   The block multiplies them, saturates the product to all nines, drops
//   leading zeros (a zero product shows one '0') and emits each ASCII digit,
//   most significant first, as six LCD port values: high nibble setup, strobe
//   high, strobe low, then the same for the low nibble. out_last_write flags
//   the final port value of the number.
//   After an item is taken the program multiplies, saturates and extracts
//   the first digit (again for each skipped leading zero) before the first
//   port value; then one port value per cycle while out_ready is high.
//   Digit extraction runs one restoring step per cycle while not stalled
//   (hidden behind the writes after the first digit); a new item is taken
//   only after the final port value of the previous one.
//   in_ready is high only in the idle step; one item is worked at a time.
//   A stall on out_ready holds the current step and its port value unchanged.
//   cfg_write_en/cfg_index/cfg_data write enable_mask (index 0) and
//   select_mask (index 1); write them only while idle.
//   Synchronous reset (rst_n low) returns the sequencer to idle and sets the
//   masks to 8 (enable) and 4 (select).
// ----------------------------------------------------------------------------
module product_to_lcd_decimal_writer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pldw_pkg::FACTOR_W-1:0]       in_factor_a,
  input  logic [pldw_pkg::FACTOR_W-1:0]       in_factor_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pldw_pkg::CHAR_W-1:0]         out_port_value,
  output logic                                out_last_write,
  input  logic                                cfg_write_en,
  input  logic [pldw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pldw_pkg::MASK_W-1:0]         cfg_data
);

  pldw_pkg::ucode_t   ctl;
  pldw_pkg::dp_stat_t stat;
  logic               go;

  logic [pldw_pkg::MASK_W-1:0] enable_mask_r, enable_mask_nxt;
  logic [pldw_pkg::MASK_W-1:0] select_mask_r, select_mask_nxt;

  // Configuration registers: write-only, taken the cycle the enable is high.
  always_comb begin
    enable_mask_nxt = enable_mask_r;
    select_mask_nxt = select_mask_r;
    if (cfg_write_en) begin
      case (cfg_index)
        pldw_pkg::REG_ENABLE_MASK: enable_mask_nxt = cfg_data;
        pldw_pkg::REG_SELECT_MASK: select_mask_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r <= pldw_pkg::ENABLE_MASK_RST;
      select_mask_r <= pldw_pkg::SELECT_MASK_RST;
    end else begin
      enable_mask_r <= enable_mask_nxt;
      select_mask_r <= select_mask_nxt;
    end
  end

  // Step counter and control store.
  pldw_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl),
    .go        (go)
  );

  // Arithmetic and port value formatting driven by the control word.
  pldw_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .go          (go),
    .factor_a    (in_factor_a),
    .factor_b    (in_factor_b),
    .enable_mask (enable_mask_r),
    .select_mask (select_mask_r),
    .stat        (stat),
    .port_value  (out_port_value),
    .last_write  (out_last_write)
  );

  // Channel handshakes come straight from the current microcode step.
  assign in_ready  = (ctl.op == pldw_pkg::OP_LOAD);
  assign out_valid = (ctl.op == pldw_pkg::OP_EMIT);

endmodule
